FILE: hw/rtl/pcienum_pkg.sv
// Shared types, constants and request formatting for the PCI config scan engine.
`timescale 1ns / 1ps

package pcienum_pkg;

    localparam int unsigned OBUF_DEPTH = 4;

    localparam logic [15:0] VID_NONE_HI = 16'hFFFF;
    localparam logic [15:0] VID_NONE_LO = 16'h0000;
    localparam logic [7:0]  OFF_ID      = 8'h00;
    localparam logic [7:0]  OFF_SUB     = 8'h2C;
    localparam logic [7:0]  OFF_HDR     = 8'd12;
    localparam int unsigned HDR_MF_BIT  = 23;
    localparam logic [1:0]  METHOD_MECH2 = 2'd2;
    localparam logic [4:0]  MAXDEV_MECH1 = 5'd31;
    localparam logic [4:0]  MAXDEV_MECH2 = 5'd15;
    localparam logic [2:0]  MAX_FUNC     = 3'd7;
    localparam logic [31:0] MECH2_PORT   = 32'h0000_C000;
    localparam logic [7:0]  MECH2_OFFMSK = 8'hFC;
    localparam logic [7:0]  MECH2_ENABLE = 8'hF0;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ID   = 2'd1,
        PH_SUB  = 2'd2,
        PH_HDR  = 2'd3
    } t_phase;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_DATA  = 1'b1
    } t_action;

    typedef enum logic {
        REG_ACCESS_METHOD = 1'b0,
        REG_HIGHEST_BUS   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [7:0]  register_offset;
        logic [31:0] access_address;
        logic [7:0]  enable_byte;
        logic [31:0] id_word;
        logic [31:0] subsystem_word;
        logic [16:0] found_count;
        logic        last;
    } t_result;

    // Format a config read for the selected mechanism.
    function automatic t_result make_request(input logic [7:0] bus, input logic [4:0] dev,
                                             input logic [2:0] fn, input logic [7:0] off,
                                             input logic mech2, input logic [16:0] count);
        t_result r;
        r                 = '0;
        r.kind            = KIND_REQUEST;
        r.bus_number      = bus;
        r.device_number   = dev;
        r.function_number = fn;
        r.register_offset = off;
        r.found_count     = count;
        if (mech2) begin
            r.enable_byte    = MECH2_ENABLE | {4'b0, fn, 1'b0};
            r.access_address = MECH2_PORT | {24'b0, off & MECH2_OFFMSK}
                               | {20'b0, dev[3:0], 8'b0};
        end else begin
            r.enable_byte    = '0;
            r.access_address = {1'b1, 7'b0, bus, dev, fn, off};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/pcienum_obuf.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high.
`timescale 1ns / 1ps

module pcienum_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push1,
    input  logic                 i_push2,
    input  pcienum_pkg::t_result i_res0,
    input  pcienum_pkg::t_result i_res1,
    output logic                 o_room2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pcienum_pkg::t_result o_res
);
    import pcienum_pkg::*;

    localparam int unsigned PW = $clog2(OBUF_DEPTH);
    localparam int unsigned CW = $clog2(OBUF_DEPTH + 1);

    t_result         r_mem [OBUF_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            pop;
    logic [PW-1:0]   wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CW'(OBUF_DEPTH - 2));
    assign o_res   = r_mem[r_rd_ptr];
    assign wr_ptr1 = r_wr_ptr + PW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push1) + PW'(i_push2);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_count  = r_count + CW'(i_push1) + CW'(i_push2) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push1) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(OBUF_DEPTH))
        else $error("result queue overflow");
    a_pair_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push2 |-> (i_push1 && r_count <= CW'(OBUF_DEPTH - 2)))
        else $error("second result pushed without room");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_wr_ptr - r_rd_ptr) == PW'(r_count))
        else $error("queue pointers disagree with fill count");

endmodule

FILE: hw/rtl/pci_config_bus_enumerator.sv
// PCI config space scan engine: top level with register port and scan state.
//
// Usage: write access_method (byte 0, 2 = mechanism 2, else mechanism 1) and
// highest_bus (byte 4) over the APB port while idle. Send an item with
// tuser = 0 to start a scan; the block answers with config read requests on
// the master stream (tuser = kind: 0 request, 1 device record, 2 done).
// Return each read's data as an item with tuser = 1. A device found yields
// a request for offset 0x2C, then a record plus a header read at offset 12.
// Throughput: one item per cycle while s_axis_tready is high; a record
// step yields two results, and the output side drains one result per
// cycle while m_axis_tready is high.
// Results go through a four-entry queue; the input is taken while two
// entries are free, so a stalled receiver backs up into s_axis_tready
// without loss. Reset (synchronous) empties the queue, returns the scan to
// idle with the count cleared, and restores mechanism 1, highest bus 0.
// Data arriving while idle is dropped and produces no result.
`timescale 1ns / 1ps

module pci_config_bus_enumerator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [31:0]   i_s_axis_tdata,   // [31:0] read_data
    input  logic          i_s_axis_tuser,   // [0] action
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [7:0] bus_number, [12:8] device_number, [15:13] function_number,
    // [23:16] register_offset, [55:24] access_address, [63:56] enable_byte,
    // [95:64] id_word, [127:96] subsystem_word, [144:128] found_count, rest 0
    output logic [151:0]  o_m_axis_tdata,
    output logic [1:0]    o_m_axis_tuser,   // [1:0] kind
    output logic          o_m_axis_tlast
);
    import pcienum_pkg::*;

    logic [1:0]  r_access_method;
    logic [7:0]  r_highest_bus;
    logic [7:0]  r_bus, n_bus;
    logic [4:0]  r_dev, n_dev;
    logic [2:0]  r_fn, n_fn;
    t_phase      r_phase, n_phase;
    logic [31:0] r_held_id, n_held_id;
    logic [16:0] r_count, n_count;

    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        acc;
    logic        room2;
    logic        mech2;
    logic [4:0]  maxdev;
    logic        skip_fn;
    logic [7:0]  adv_bus;
    logic [4:0]  adv_dev;
    logic [2:0]  adv_fn;
    logic        adv_more;
    logic [15:0] vid;
    logic        push1, push2;
    t_result     res0, res1, out_res;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_method <= 2'd1;
            r_highest_bus   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ACCESS_METHOD: r_access_method <= pwdata[1:0];
                REG_HIGHEST_BUS:   r_highest_bus   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ACCESS_METHOD: prdata = {30'b0, r_access_method};
            REG_HIGHEST_BUS:   prdata = {24'b0, r_highest_bus};
            default:           prdata = '0;
        endcase
    end

    // ---------------- scan step ----------------
    assign acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign mech2   = (r_access_method == METHOD_MECH2);
    assign maxdev  = mech2 ? MAXDEV_MECH2 : MAXDEV_MECH1;
    assign vid     = i_s_axis_tdata[15:0];
    // single-function device: skip the rest of its functions
    assign skip_fn = (r_phase == PH_HDR) && !i_s_axis_tdata[HDR_MF_BIT];

    always_comb begin
        adv_bus  = r_bus;
        adv_dev  = r_dev;
        adv_fn   = r_fn;
        adv_more = 1'b1;
        if (!skip_fn && r_fn < MAX_FUNC) begin
            adv_fn = r_fn + 3'd1;
        end else if (r_dev < maxdev) begin
            adv_fn  = '0;
            adv_dev = r_dev + 5'd1;
        end else if (r_bus < r_highest_bus) begin
            adv_fn  = '0;
            adv_dev = '0;
            adv_bus = r_bus + 8'd1;
        end else begin
            adv_fn   = '0;
            adv_dev  = '0;
            adv_bus  = '0;
            adv_more = 1'b0;
        end
    end

    always_comb begin
        n_bus     = r_bus;
        n_dev     = r_dev;
        n_fn      = r_fn;
        n_phase   = r_phase;
        n_held_id = r_held_id;
        n_count   = r_count;
        res0      = '0;
        res1      = '0;
        push1     = 1'b0;
        push2     = 1'b0;
        if (acc) begin
            if (t_action'(i_s_axis_tuser) == ACT_START) begin
                n_bus     = '0;
                n_dev     = '0;
                n_fn      = '0;
                n_count   = '0;
                n_held_id = '0;
                n_phase   = PH_ID;
                res0      = make_request('0, '0, '0, OFF_ID, mech2, '0);
                res0.last = 1'b1;
                push1     = 1'b1;
            end else begin
                case (r_phase)
                    PH_ID, PH_HDR: begin
                        push1 = 1'b1;
                        if (r_phase == PH_ID && vid != VID_NONE_HI && vid != VID_NONE_LO) begin
                            n_held_id = i_s_axis_tdata;
                            n_count   = r_count + 17'd1;
                            n_phase   = PH_SUB;
                            res0      = make_request(r_bus, r_dev, r_fn, OFF_SUB, mech2,
                                                     r_count + 17'd1);
                        end else if (adv_more) begin
                            n_bus   = adv_bus;
                            n_dev   = adv_dev;
                            n_fn    = adv_fn;
                            n_phase = PH_ID;
                            res0    = make_request(adv_bus, adv_dev, adv_fn, OFF_ID, mech2,
                                                   r_count);
                        end else begin
                            n_bus             = '0;
                            n_dev             = '0;
                            n_fn              = '0;
                            n_phase           = PH_IDLE;
                            res0.kind         = KIND_DONE;
                            res0.found_count  = r_count;
                        end
                        res0.last = 1'b1;
                    end
                    PH_SUB: begin
                        res0.kind            = KIND_RECORD;
                        res0.bus_number      = r_bus;
                        res0.device_number   = r_dev;
                        res0.function_number = r_fn;
                        res0.id_word         = r_held_id;
                        res0.subsystem_word  = i_s_axis_tdata;
                        res0.found_count     = r_count;
                        res1      = make_request(r_bus, r_dev, r_fn, OFF_HDR, mech2, r_count);
                        res1.last = 1'b1;
                        n_phase   = PH_HDR;
                        push1     = 1'b1;
                        push2     = 1'b1;
                    end
                    default: ;  // drop data while idle
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus     <= '0;
            r_dev     <= '0;
            r_fn      <= '0;
            r_phase   <= PH_IDLE;
            r_held_id <= '0;
            r_count   <= '0;
        end else begin
            r_bus     <= n_bus;
            r_dev     <= n_dev;
            r_fn      <= n_fn;
            r_phase   <= n_phase;
            r_held_id <= n_held_id;
            r_count   <= n_count;
        end
    end

    // ---------------- result queue ----------------
    pcienum_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push1 (push1),
        .i_push2 (push2),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_s_axis_tready = room2;
    assign o_m_axis_tuser  = out_res.kind;
    assign o_m_axis_tlast  = out_res.last;
    assign o_m_axis_tdata  = {7'b0, out_res.found_count, out_res.subsystem_word,
                              out_res.id_word, out_res.enable_byte, out_res.access_address,
                              out_res.register_offset, out_res.function_number,
                              out_res.device_number, out_res.bus_number};

    a_start_to_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_s_axis_tuser) |=> (r_phase == PH_ID && r_count == '0))
        else $error("start did not restart the scan");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 17'd1 || r_count == '0))
        else $error("device count jumped");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_s_axis_tuser && r_phase == PH_IDLE) |-> (!push1 && !push2))
        else $error("result produced from idle data");
    a_pair_only_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push2 |-> (r_phase == PH_SUB && n_phase == PH_HDR))
        else $error("two results outside record step");

endmodule
